// ----- src/gmsms_pkg.sv -----
// Shared types, constants and the kernel weight table of the mean-shift mode seeker.
// No dependencies; every other module imports this package, the two interfaces do not.
package gmsms_pkg;

   // sizes
   localparam int MAX_POINTS      = 1024;
   localparam int DIMS            = 4;
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int ADDR_W          = $clog2(MAX_POINTS);
   localparam int COUNT_W         = ADDR_W + 1;
   localparam int TAB_IW          = $clog2(EXP_TABLE_DEPTH);
   localparam int COORD_W         = 16;
   localparam int POINT_W         = COORD_W * DIMS;
   localparam int SQ_W            = 32;
   localparam int DIST_W          = 34;
   localparam int PROD_W          = 50;
   localparam int ARG_SHIFT       = 20;
   localparam int ARG_W           = PROD_W - ARG_SHIFT;
   localparam int WP_W            = 33;
   localparam int SUM_W           = 48;
   localparam int WT_W            = 28;
   localparam int NUM_W           = 50;
   localparam int QUOT_W          = 17;
   localparam int MOVE_W          = 35;
   localparam int THR_W           = 36;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 64;

   localparam logic [31:0] EXP_DECAY = 32'd61565;

   // request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_SEEK  = 2'd2;

   // status codes
   localparam logic [1:0] STAT_CONVERGED = 2'd0;
   localparam logic [1:0] STAT_CAP_HIT   = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_ZERO_WT   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_KERNEL_SCALE   = 2'd0;
   localparam logic [1:0] REG_STOP_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;
   localparam logic [1:0] REG_DIMS_IN_USE    = 2'd3;

   typedef struct packed {
      logic [15:0]      kernel_scale;
      logic [THR_W-1:0] stop_threshold;
      logic [7:0]       max_iterations;
      logic [2:0]       dims_in_use;
   } cfg_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] sum;
      logic [WT_W-1:0]         total;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [COORD_W-1:0] quot;
   } div_rsp_type;

   typedef logic [15:0] kern_tab_type [EXP_TABLE_DEPTH];

   // exp(-k/16) in Q0.16, built at elaboration
   function automatic kern_tab_type kern_tab_build();
      kern_tab_type t;
      logic [31:0]  v;
      v = 32'd65535;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         t[k] = v[15:0];
         v = (v * EXP_DECAY + 32'd32768) >> 16;
      end
      return t;
   endfunction

   localparam kern_tab_type KERN_TAB = kern_tab_build();

endpackage

// ----- src/gmsms_req_if.sv -----
// Request channel of the mean-shift mode seeker: valid/ready plus request payload.
// Depends on nothing.
interface gmsms_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [15:0] coord_0;
   logic signed [15:0] coord_1;
   logic signed [15:0] coord_2;
   logic signed [15:0] coord_3;

   modport source (output valid, req_type, coord_0, coord_1, coord_2, coord_3, input ready);
   modport sink (input valid, req_type, coord_0, coord_1, coord_2, coord_3, output ready);
endinterface

// ----- src/gmsms_rsp_if.sv -----
// Result channel of the mean-shift mode seeker: valid/ready plus mode, count and status.
// Depends on nothing.
interface gmsms_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] mode_0;
   logic signed [15:0] mode_1;
   logic signed [15:0] mode_2;
   logic signed [15:0] mode_3;
   logic [7:0]         iterations_used;
   logic [1:0]         status;

   modport source (output valid, mode_0, mode_1, mode_2, mode_3, iterations_used, status,
                   input ready);
   modport sink (input valid, mode_0, mode_1, mode_2, mode_3, iterations_used, status,
                 output ready);
endinterface

// ----- src/gmsms_point_mem.sv -----
// Point store: one write port, one read port, registered read data.
// Depends on gmsms_pkg.
module gmsms_point_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [gmsms_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [gmsms_pkg::POINT_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [gmsms_pkg::ADDR_W-1:0]  rd_addr,
   output logic [gmsms_pkg::POINT_W-1:0] rd_data
);
   import gmsms_pkg::*;

   logic [POINT_W-1:0] store_ff [MAX_POINTS];
   logic [POINT_W-1:0] rd_data_ff;

   // write on request
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/gmsms_div.sv -----
// Rounded, saturating divider: sum / total, ties away from zero, one quotient bit per cycle.
// Depends on gmsms_pkg.
module gmsms_div (
   input  logic                   clock,
   input  logic                   reset,
   input  gmsms_pkg::div_req_type req,
   output gmsms_pkg::div_rsp_type rsp
);
   import gmsms_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [NUM_W-1:0]      rem_ff, rem_in;
   logic [NUM_W-1:0]      dsh_ff, dsh_in;
   logic [QUOT_W-1:0]     q_ff, q_in;
   logic signed [COORD_W-1:0] res_ff, res_in;
   logic [SUM_W-1:0]      mag;
   logic                  ge;

   assign mag = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
   assign ge  = rem_ff >= dsh_ff;

   // load on start, then subtract shifted divisor once a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      res_in  = res_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd16;
         neg_in  = req.sum[SUM_W-1];
         rem_in  = NUM_W'({mag, 1'b0}) + NUM_W'(req.total);
         dsh_in  = NUM_W'({req.total, 1'b0}) << 16;
         q_in    = '0;
      end else if (busy_ff) begin
         q_in   = {q_ff[QUOT_W-2:0], ge};
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               res_in = (q_in > QUOT_W'(32767)) ? 16'sh7fff : $signed(q_in[15:0]);
            end else begin
               res_in = (q_in > QUOT_W'(32768)) ? -16'sh8000 : $signed(-q_in[15:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = res_ff;
endmodule

// ----- src/gmsms_csr.sv -----
// Configuration registers behind an APB-style port, 64-bit data, register i at 8*i.
// Depends on gmsms_pkg.
module gmsms_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gmsms_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gmsms_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gmsms_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output gmsms_pkg::cfg_type              cfg
);
   import gmsms_pkg::*;

   cfg_type    cfg_ff;
   logic [1:0] idx;
   logic       wr;

   assign idx = csr_paddr[4:3];
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   // write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_scale   <= 16'd256;
         cfg_ff.stop_threshold <= THR_W'(256);
         cfg_ff.max_iterations <= 8'd32;
         cfg_ff.dims_in_use    <= 3'd4;
      end else if (wr) begin
         unique case (idx)
            REG_KERNEL_SCALE:   cfg_ff.kernel_scale   <= csr_pwdata[15:0];
            REG_STOP_THRESHOLD: cfg_ff.stop_threshold <= csr_pwdata[THR_W-1:0];
            REG_MAX_ITERATIONS: cfg_ff.max_iterations <= csr_pwdata[7:0];
            REG_DIMS_IN_USE:    cfg_ff.dims_in_use    <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_KERNEL_SCALE:   csr_prdata = CSR_DATA_W'(cfg_ff.kernel_scale);
         REG_STOP_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.stop_threshold);
         REG_MAX_ITERATIONS: csr_prdata = CSR_DATA_W'(cfg_ff.max_iterations);
         REG_DIMS_IN_USE:    csr_prdata = CSR_DATA_W'(cfg_ff.dims_in_use);
         default:            csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;
endmodule

// ----- src/gaussian_mean_shift_mode_seek.sv -----
// Top level of the Gaussian mean-shift mode seeker: sequencer, point pipeline, accumulators.
// Depends on gmsms_pkg, gmsms_req_if, gmsms_rsp_if, gmsms_point_mem, gmsms_div, gmsms_csr.
//
//   channel  direction  handshake             payload
//   req_ch   in         valid/ready           req_type, coord_0..coord_3
//   rsp_ch   out        valid/ready           mode_0..mode_3, iterations_used, status
//   csr_*    in/out     psel/penable/pready   paddr, pwdata, prdata
//
// Load and clear complete without leaving the idle state. In each seek iteration, one point
// per cycle streams from the point store read port through the point pipeline into the
// accumulators, then the shared divider works through the dimensions one at a time.
// Reset clears control state only; the point store needs no clearing pass.
// The result sits in an output register; a new item is taken while it waits, and a
// seek that finishes before the old result is taken holds until it is.
module gaussian_mean_shift_mode_seek (
   input  logic                            clock,
   input  logic                            reset,
   gmsms_req_if.sink                       req_ch,
   gmsms_rsp_if.source                     rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gmsms_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gmsms_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gmsms_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import gmsms_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_DFIN = 3'd3;
   localparam logic [2:0] ST_DACC = 3'd4;
   localparam logic [2:0] ST_NEXT = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        div_start;

   logic [2:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  scan_ff, scan_in;
   logic [2:0]          nd_ff, nd_in;
   logic [7:0]          cap_ff, cap_in;
   logic [7:0]          iters_ff, iters_in;
   logic [1:0]          stat_ff, stat_in;
   logic [1:0]          dim_ff, dim_in;
   logic signed [COORD_W-1:0] est_ff [DIMS];
   logic signed [COORD_W-1:0] est_in [DIMS];
   logic signed [COORD_W-1:0] next_ff [DIMS];
   logic signed [COORD_W-1:0] next_in [DIMS];
   logic signed [COORD_W-1:0] q_ff, q_in;
   logic [SQ_W-1:0]     msq_ff, msq_in;
   logic [MOVE_W-1:0]   move_ff, move_in;
   logic                acc_clr;

   logic                req_fire, rsp_load;
   logic                rsp_vld_ff, rsp_vld_in;
   logic signed [COORD_W-1:0] mode_ff [DIMS];
   logic [7:0]          out_iters_ff;
   logic [1:0]          out_stat_ff;

   logic                mem_wr, rd_en;
   logic [POINT_W-1:0]  rd_data;
   logic [POINT_W-1:0]  req_point;
   logic signed [COORD_W-1:0] req_coord [DIMS];

   // pipeline
   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [SQ_W-1:0]     sq2_ff [DIMS];
   logic [SQ_W-1:0]     sq2_in [DIMS];
   logic [POINT_W-1:0]  pt2_ff, pt3_ff, pt4_ff, pt5_ff;
   logic [DIST_W-1:0]   dist3_ff;
   logic [PROD_W-1:0]   prod4_ff;
   logic [15:0]         w5_ff, w5_in, w6_ff;
   logic [ARG_W-1:0]    arg4;
   logic signed [WP_W-1:0] wp6_ff [DIMS];
   logic signed [WP_W-1:0] wp6_in [DIMS];
   logic signed [SUM_W-1:0] sum_ff [DIMS];
   logic [WT_W-1:0]     wt_ff;
   logic                pipe_busy, scan_done;

   logic signed [COORD_W:0] dd;

   gmsms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gmsms_point_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_point),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   gmsms_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_coord[0] = req_ch.coord_0;
   assign req_coord[1] = req_ch.coord_1;
   assign req_coord[2] = req_ch.coord_2;
   assign req_coord[3] = req_ch.coord_3;
   assign req_point    = {req_ch.coord_3, req_ch.coord_2, req_ch.coord_1, req_ch.coord_0};

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign mem_wr       = req_fire && (req_ch.req_type == REQ_LOAD)
                         && (count_ff < COUNT_W'(MAX_POINTS));
   assign rd_en        = (state_ff == ST_SCAN) && (scan_ff < count_ff);
   assign pipe_busy    = v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || v6_ff;
   assign scan_done    = (state_ff == ST_SCAN) && !rd_en && !pipe_busy;
   assign rsp_load     = (state_ff == ST_OUT) && (!rsp_vld_ff || rsp_ch.ready);

   // divider feed: the sum of the dimension being started
   assign div_req.start = div_start;
   assign div_req.sum   = sum_ff[dim_in];
   assign div_req.total = wt_ff;

   assign dd = {q_ff[COORD_W-1], q_ff} - {est_ff[dim_ff][COORD_W-1], est_ff[dim_ff]};

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = rd_en ? scan_ff + COUNT_W'(1) : scan_ff;
      nd_in    = nd_ff;
      cap_in   = cap_ff;
      iters_in = iters_ff;
      stat_in  = stat_ff;
      dim_in   = dim_ff;
      est_in   = est_ff;
      next_in  = next_ff;
      q_in     = q_ff;
      msq_in   = msq_ff;
      move_in  = move_ff;
      acc_clr  = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.req_type)
                  REQ_LOAD: begin
                     if (mem_wr) count_in = count_ff + COUNT_W'(1);
                  end
                  REQ_CLEAR: count_in = '0;
                  REQ_SEEK: begin
                     nd_in = (cfg.dims_in_use == 3'd0) ? 3'd1 :
                             (cfg.dims_in_use > 3'(DIMS)) ? 3'(DIMS) : cfg.dims_in_use;
                     cap_in   = (cfg.max_iterations == 8'd0) ? 8'd1 : cfg.max_iterations;
                     iters_in = '0;
                     for (int j = 0; j < DIMS; j++) begin
                        est_in[j] = (3'(j) < nd_in) ? req_coord[j] : '0;
                     end
                     if (count_ff == '0) begin
                        stat_in  = STAT_EMPTY;
                        state_in = ST_OUT;
                     end else begin
                        acc_clr  = 1'b1;
                        scan_in  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (wt_ff == '0) begin
                  stat_in  = STAT_ZERO_WT;
                  state_in = ST_OUT;
               end else begin
                  iters_in  = iters_ff + 8'd1;
                  dim_in    = '0;
                  move_in   = '0;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               q_in     = ({1'b0, dim_ff} < nd_ff) ? div_rsp.quot : '0;
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            next_in[dim_ff] = q_ff;
            msq_in   = SQ_W'(dd * dd);
            state_in = ST_DACC;
         end
         ST_DACC: begin
            move_in = move_ff + MOVE_W'(msq_ff);
            if (dim_ff == 2'(DIMS - 1)) begin
               state_in = ST_NEXT;
            end else begin
               dim_in    = dim_ff + 2'd1;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_NEXT: begin
            est_in = next_ff;
            if ({1'b0, move_ff} <= cfg.stop_threshold) begin
               stat_in  = STAT_CONVERGED;
               state_in = ST_OUT;
            end else if (iters_ff >= cap_ff) begin
               stat_in  = STAT_CAP_HIT;
               state_in = ST_OUT;
            end else begin
               acc_clr  = 1'b1;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_OUT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      nd_ff    <= nd_in;
      cap_ff   <= cap_in;
      iters_ff <= iters_in;
      stat_ff  <= stat_in;
      dim_ff   <= dim_in;
      est_ff   <= est_in;
      next_ff  <= next_in;
      q_ff     <= q_in;
      msq_ff   <= msq_in;
      move_ff  <= move_in;
   end

   // stage 2: per-dimension squared differences
   always_comb begin
      logic signed [COORD_W:0] d;
      logic signed [COORD_W-1:0] pc;
      for (int j = 0; j < DIMS; j++) begin
         pc = $signed(rd_data[COORD_W*j +: COORD_W]);
         d  = {pc[COORD_W-1], pc} - {est_ff[j][COORD_W-1], est_ff[j]};
         sq2_in[j] = (3'(j) < nd_ff) ? SQ_W'(d * d) : '0;
      end
   end

   // stage 5: kernel weight lookup
   assign arg4  = prod4_ff[PROD_W-1:ARG_SHIFT];
   assign w5_in = (arg4 < ARG_W'(EXP_TABLE_DEPTH)) ? KERN_TAB[arg4[TAB_IW-1:0]] : 16'd0;

   // stage 6: weight times coordinate
   always_comb begin
      for (int j = 0; j < DIMS; j++) begin
         wp6_in[j] = WP_W'($signed({1'b0, w5_ff}) * $signed(pt5_ff[COORD_W*j +: COORD_W]));
      end
   end

   // advance pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      sq2_ff   <= sq2_in;
      pt2_ff   <= rd_data;
      dist3_ff <= DIST_W'(sq2_ff[0]) + DIST_W'(sq2_ff[1])
                + DIST_W'(sq2_ff[2]) + DIST_W'(sq2_ff[3]);
      pt3_ff   <= pt2_ff;
      prod4_ff <= PROD_W'(cfg.kernel_scale * dist3_ff);
      pt4_ff   <= pt3_ff;
      w5_ff    <= w5_in;
      pt5_ff   <= pt4_ff;
      wp6_ff   <= wp6_in;
      w6_ff    <= w5_ff;
   end

   // accumulate weights and weighted coordinates
   always_ff @(posedge clock) begin
      if (acc_clr) begin
         wt_ff <= '0;
         for (int j = 0; j < DIMS; j++) sum_ff[j] <= '0;
      end else if (v6_ff) begin
         wt_ff <= wt_ff + WT_W'(w6_ff);
         for (int j = 0; j < DIMS; j++) sum_ff[j] <= sum_ff[j] + SUM_W'(wp6_ff[j]);
      end
   end

   // output register
   assign rsp_vld_in = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         mode_ff      <= est_ff;
         out_iters_ff <= iters_ff;
         out_stat_ff  <= stat_ff;
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.mode_0          = mode_ff[0];
   assign rsp_ch.mode_1          = mode_ff[1];
   assign rsp_ch.mode_2          = mode_ff[2];
   assign rsp_ch.mode_3          = mode_ff[3];
   assign rsp_ch.iterations_used = out_iters_ff;
   assign rsp_ch.status          = out_stat_ff;

   // point count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   // the pipeline is empty whenever a new item can enter
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !pipe_busy)
      else $error("point pipeline busy while idle");

   // the divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider result outside divide state");

   // iteration count never passes the cap during a seek
   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (iters_ff < cap_ff))
      else $error("scan started beyond iteration cap");

   // a loaded result is presented on the next cycle
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_vld_ff)
      else $error("result lost at load");
endmodule
